### rtl/pcf_pkg.sv
package pcf_pkg;

   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_DATA  = 2'd1,
      CMD_END   = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      JOB_START = 2'd0,
      JOB_DATA  = 2'd1,
      JOB_END   = 2'd2
   } job_kind_type;

   // one queued job: start carries length and type word, data the byte in val[7:0],
   // end the final CRC and the mismatch flag
   typedef struct packed {
      job_kind_type kind;
      logic [30:0]  len;
      logic [31:0]  val;
      logic         mis;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } queue_wr_type;

   // reflected CRC-32, one byte folded in
   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/pcf_req_if.sv
interface pcf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [30:0] data_length;
   logic [7:0]  data_byte;

   modport source (output valid, command, data_length, data_byte, input ready);
   modport sink (input valid, command, data_length, data_byte, output ready);
endinterface

### rtl/pcf_rsp_if.sv
interface pcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       length_mismatch;

   modport source (output valid, out_byte, last, length_mismatch, input ready);
   modport sink (input valid, out_byte, last, length_mismatch, output ready);
endinterface

### rtl/pcf_front.sv
module pcf_front (
   input  logic                    clock,
   input  logic                    reset,
   pcf_req_if.sink                 req,
   input  logic [31:0]             chunk_type,
   input  logic                    queue_full,
   output pcf_pkg::queue_wr_type   qwr
);

   logic [31:0] crc_ff, crc_in;
   logic [30:0] count_ff, count_in;
   logic [30:0] decl_ff, decl_in;
   logic        in_chunk_ff, in_chunk_in;
   logic        seeding_ff, seeding_in;
   logic [1:0]  seed_cnt_ff, seed_cnt_in;
   logic [7:0]  seed_byte;
   logic        accept;

   assign req.ready = !seeding_ff && !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      case (seed_cnt_ff)
         2'd0:    seed_byte = chunk_type[31:24];
         2'd1:    seed_byte = chunk_type[23:16];
         2'd2:    seed_byte = chunk_type[15:8];
         default: seed_byte = chunk_type[7:0];
      endcase
   end

   always_comb begin
      crc_in      = crc_ff;
      count_in    = count_ff;
      decl_in     = decl_ff;
      in_chunk_in = in_chunk_ff;
      seeding_in  = seeding_ff;
      seed_cnt_in = seed_cnt_ff;
      qwr.push     = 1'b0;
      qwr.job.kind = pcf_pkg::JOB_DATA;
      qwr.job.len  = req.data_length;
      qwr.job.val  = {24'd0, req.data_byte};
      qwr.job.mis  = 1'b0;

      if (seeding_ff) begin
         // fold type bytes, one per cycle
         crc_in      = pcf_pkg::crc_fold(crc_ff, seed_byte);
         seed_cnt_in = seed_cnt_ff + 2'd1;
         if (seed_cnt_ff == 2'd3) begin
            seeding_in = 1'b0;
         end
      end else if (accept) begin
         case (pcf_pkg::command_type'(req.command))
            pcf_pkg::CMD_START: begin
               qwr.push     = 1'b1;
               qwr.job.kind = pcf_pkg::JOB_START;
               qwr.job.val  = chunk_type;
               crc_in       = pcf_pkg::CRC_ONES;
               count_in     = '0;
               decl_in      = req.data_length;
               in_chunk_in  = 1'b1;
               seeding_in   = 1'b1;
               seed_cnt_in  = '0;
            end
            pcf_pkg::CMD_DATA: begin
               if (in_chunk_ff) begin
                  qwr.push = 1'b1;
                  crc_in   = pcf_pkg::crc_fold(crc_ff, req.data_byte);
                  if (count_ff != pcf_pkg::COUNT_MAX) begin
                     count_in = count_ff + 31'd1;
                  end
               end
            end
            pcf_pkg::CMD_END: begin
               if (in_chunk_ff) begin
                  qwr.push     = 1'b1;
                  qwr.job.kind = pcf_pkg::JOB_END;
                  qwr.job.val  = crc_ff ^ pcf_pkg::CRC_ONES;
                  qwr.job.mis  = (count_ff != decl_ff);
                  crc_in       = pcf_pkg::CRC_ONES;
                  count_in     = '0;
                  in_chunk_in  = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= pcf_pkg::CRC_ONES;
         count_ff    <= '0;
         decl_ff     <= '0;
         in_chunk_ff <= 1'b0;
         seeding_ff  <= 1'b0;
         seed_cnt_ff <= '0;
      end else begin
         crc_ff      <= crc_in;
         count_ff    <= count_in;
         decl_ff     <= decl_in;
         in_chunk_ff <= in_chunk_in;
         seeding_ff  <= seeding_in;
         seed_cnt_ff <= seed_cnt_in;
      end
   end

endmodule

### rtl/pcf_queue.sv
module pcf_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pcf_pkg::queue_wr_type qwr,
   output logic                  full,
   output logic                  head_valid,
   output pcf_pkg::job_type      head,
   input  logic                  pop
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pcf_pkg::job_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = qwr.push && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= qwr.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### rtl/pcf_back.sv
module pcf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  pcf_pkg::job_type head,
   output logic             pop,
   pcf_rsp_if.source        rsp
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       mis_ff, mis_in;
   logic       load;
   logic       job_done;
   logic [7:0] sel_byte;
   logic       sel_last;
   logic       sel_mis;

   assign rsp.valid           = valid_ff;
   assign rsp.out_byte        = byte_ff;
   assign rsp.last            = last_ff;
   assign rsp.length_mismatch = mis_ff;

   assign load = head_valid && (!valid_ff || rsp.ready);
   assign pop  = load && job_done;

   always_comb begin
      sel_byte = head.val[7:0];
      sel_last = 1'b0;
      sel_mis  = 1'b0;
      job_done = 1'b1;
      case (head.kind)
         pcf_pkg::JOB_START: begin
            job_done = (idx_ff == 3'd7);
            case (idx_ff)
               3'd0:    sel_byte = {1'b0, head.len[30:24]};
               3'd1:    sel_byte = head.len[23:16];
               3'd2:    sel_byte = head.len[15:8];
               3'd3:    sel_byte = head.len[7:0];
               3'd4:    sel_byte = head.val[31:24];
               3'd5:    sel_byte = head.val[23:16];
               3'd6:    sel_byte = head.val[15:8];
               default: sel_byte = head.val[7:0];
            endcase
         end
         pcf_pkg::JOB_END: begin
            job_done = (idx_ff == 3'd3);
            sel_last = (idx_ff == 3'd3);
            sel_mis  = head.mis;
            case (idx_ff[1:0])
               2'd0:    sel_byte = head.val[31:24];
               2'd1:    sel_byte = head.val[23:16];
               2'd2:    sel_byte = head.val[15:8];
               default: sel_byte = head.val[7:0];
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      mis_in   = mis_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = sel_byte;
         last_in  = sel_last;
         mis_in   = sel_mis;
         idx_in   = job_done ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      mis_ff  <= mis_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

### rtl/png_chunk_framer_crc32_unit.sv
// PNG-style chunk framer with CRC-32. Transactions on req carry a command: start
// (declared data length), data (one payload byte) or end. Start yields 8 rsp
// transactions (4 length bytes big-endian, then the 4 chunk_type bytes), data yields
// its byte, end yields the 4 CRC bytes MSB first with last on the final one and
// length_mismatch on all four if the data count differs from the declared length.
// Data/end outside a chunk and command 3 are accepted and dropped. Rate: data
// transactions go at one per cycle unless the queue is full; after a start, req stalls
// while the CRC seed is folded from the type bytes, one byte per cycle; on the output side
// a start yields 8 bytes and an end 4, so the output register sets the rate there.
// A QUEUE_DEPTH-entry job queue between front and back lets each side stall alone.
// chunk_type is written through the APB port at address 0.
module png_chunk_framer_crc32_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   pcf_req_if.sink     req,
   pcf_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [31:0]           chunk_type_ff;
   logic                  queue_full;
   logic                  head_valid;
   logic                  pop;
   pcf_pkg::job_type      head;
   pcf_pkg::queue_wr_type qwr;

   // config register, single word decoded at addresses 0 to 3 (paddr[2] low)
   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? chunk_type_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_type_ff <= '0;
      end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
         chunk_type_ff <= pwdata;
      end
   end

   // front: accept, classify, CRC and count state
   pcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .chunk_type (chunk_type_ff),
      .queue_full (queue_full),
      .qwr        (qwr)
   );

   // job queue
   pcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .qwr        (qwr),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   // back: expand jobs into bytes, registered output
   pcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

### dv/pcf_tb_pkg.sv
package pcf_tb_pkg;
   import pcf_pkg::*;

   // one framed byte as seen on rsp
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       length_mismatch;
   } framed_byte_t;

   // Tracks the chunk being framed and queues the bytes the framer owes.
   class chunk_byte_tracker;
      logic [31:0]  chunk_type;
      logic [31:0]  crc_state;
      logic [30:0]  data_count;
      logic [30:0]  declared_len;
      bit           open;
      framed_byte_t expected_bytes[$];

      int mismatches;
      int checked;
      int busy_requests;
      int chunks_closed;
      int bad_length_chunks;
      int abandoned;
      int dropped;

      function new();
         chunk_type = '0;
         crc_state = CRC_ONES;
         data_count = '0;
         declared_len = '0;
         open = 1'b0;
         mismatches = 0;
         checked = 0;
         busy_requests = 0;
         chunks_closed = 0;
         bad_length_chunks = 0;
         abandoned = 0;
         dropped = 0;
      endfunction

      function void set_chunk_type(input logic [31:0] value);
         chunk_type = value;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      static function logic [31:0] crc32_fold_byte(input logic [31:0] crc,
                                                   input logic [7:0] b);
         logic [31:0] c;
         c = crc ^ {24'h0, b};
         for (int k = 0; k < 8; k++) begin
            c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'h0);
         end
         return c;
      endfunction

      function void owe_byte(input logic [7:0] b, input logic last, input logic mis);
         framed_byte_t fb;
         fb.out_byte = b;
         fb.last = last;
         fb.length_mismatch = mis;
         expected_bytes.push_back(fb);
      endfunction

      // predicts the framed bytes of one accepted request
      function void note_request(input command_type cmd, input logic [30:0] len,
                                 input logic [7:0] data);
         logic [31:0] len_word;
         logic [31:0] crc_out;
         logic        mis;
         case (cmd)
            CMD_START: begin
               if (open) abandoned++;
               len_word = {1'b0, len};
               for (int i = 3; i >= 0; i--) owe_byte(len_word[8*i +: 8], 1'b0, 1'b0);
               crc_state = CRC_ONES;
               for (int i = 3; i >= 0; i--) begin
                  owe_byte(chunk_type[8*i +: 8], 1'b0, 1'b0);
                  crc_state = crc32_fold_byte(crc_state, chunk_type[8*i +: 8]);
               end
               data_count = '0;
               declared_len = len;
               open = 1'b1;
               busy_requests++;
            end
            CMD_DATA: begin
               if (open) begin
                  owe_byte(data, 1'b0, 1'b0);
                  crc_state = crc32_fold_byte(crc_state, data);
                  if (data_count != COUNT_MAX) data_count++;
                  busy_requests++;
               end else begin
                  dropped++;
               end
            end
            CMD_END: begin
               if (open) begin
                  crc_out = crc_state ^ CRC_ONES;
                  mis = (data_count != declared_len);
                  for (int i = 3; i >= 0; i--) owe_byte(crc_out[8*i +: 8], i == 0, mis);
                  if (mis) bad_length_chunks++;
                  chunks_closed++;
                  crc_state = CRC_ONES;
                  data_count = '0;
                  open = 1'b0;
                  busy_requests++;
               end else begin
                  dropped++;
               end
            end
            default: dropped++;
         endcase
      endfunction

      function void check_result(input logic [7:0] b, input logic last, input logic mis);
         framed_byte_t want;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected byte: got byte=%02h last=%0b mis=%0b",
                        $realtime, b, last, mis);
            return;
         end
         want = expected_bytes.pop_front();
         checked++;
         if (want.out_byte !== b || want.last !== last || want.length_mismatch !== mis) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] byte %0d: exp byte=%02h last=%0b mis=%0b, got byte=%02h last=%0b mis=%0b",
                        $realtime, checked, want.out_byte, want.last,
                        want.length_mismatch, b, last, mis);
         end
      endfunction
   endclass

endpackage

### dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pcf_pkg::*;
   import pcf_tb_pkg::*;

   // chunk_type is register 0 of the APB map
   localparam logic [2:0] CHUNK_TYPE_ADDR = 3'd0;
   // cycles to let a dropped command clear the pipe before a CSR write
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_GOAL = 100;

   logic clock;
   logic reset;

   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   pcf_req_if req_bus();
   pcf_rsp_if rsp_bus();

   png_chunk_framer_crc32_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   chunk_byte_tracker tracker;

   // steady_flow: no idle cycles on either side (one phase runs this way)
   bit steady_flow;
   bit pressure_done;
   int stall_left;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop in case the framer hangs
   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // idle length: mostly none or short, now and then long
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   // rsp side: check every transaction, then pick the next ready value
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_result(rsp_bus.out_byte, rsp_bus.last, rsp_bus.length_mismatch);
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!steady_flow && $urandom_range(0, 99) < 25) stall_left <= idle_span();
      end
   end

   // one req transaction; valid stays high on return so back-to-back items need no bubble
   task automatic send_request(input command_type cmd, input logic [30:0] len,
                               input logic [7:0] data);
      int gap;
      gap = idle_span();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.data_length <= len;
      req_bus.data_byte   <= data;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_request(cmd, len, data);
   endtask

   // drop valid and wait until every owed byte has come out
   task automatic drain_results(input int extra);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (extra) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; register updates at the pready edge
   task automatic write_chunk_type(input logic [31:0] value);
      drain_results(SETTLE_CYCLES);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CHUNK_TYPE_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      tracker.set_chunk_type(value);
   endtask

   // Random chunks: mostly well-formed (start, N data, end) with random bytes,
   // some with a wrong declared length, some abandoned, plus stray commands.
   task automatic run_random_chunks(input int goal);
      int          base;
      int          n_data;
      int          pick;
      logic [30:0] declared;
      command_type cmd;
      base = tracker.busy_requests;
      while (tracker.busy_requests - base < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 82) begin
            n_data = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 48)
                                                  : $urandom_range(0, 12);
            pick = $urandom_range(0, 99);
            if (pick < 75)      declared = 31'(n_data);
            else if (pick < 90) declared = 31'(n_data + $urandom_range(1, 3));
            else if (pick < 95) declared = (n_data > 0) ? 31'(n_data - 1) : 31'd1;
            else                declared = 31'($urandom);
            send_request(CMD_START, declared, 8'($urandom));
            for (int i = 0; i < n_data; i++) begin
               if ($urandom_range(0, 19) == 0)
                  send_request(CMD_NONE, 31'($urandom), 8'($urandom));
               // hold the sender mid-chunk until the framer has caught up
               if (!pressure_done && tracker.busy_requests - base > goal / 2) begin
                  drain_results(0);
                  pressure_done = 1'b1;
               end
               send_request(CMD_DATA, 31'($urandom), 8'($urandom));
            end
            // one in ten chunks is left open and gets cut off by the next start
            if ($urandom_range(0, 9) != 0)
               send_request(CMD_END, 31'($urandom), 8'($urandom));
         end else begin
            cmd = command_type'($urandom_range(0, 3));
            send_request(cmd, 31'($urandom), 8'($urandom));
         end
      end
   endtask

   logic [31:0] phase_types [5];

   initial begin
      tracker       = new();
      steady_flow   = 1'b0;
      pressure_done = 1'b0;
      stall_left    = 0;
      reset         = 1'b1;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      req_bus.valid       = 1'b0;
      req_bus.command     = CMD_NONE;
      req_bus.data_length = '0;
      req_bus.data_byte   = '0;
      rsp_bus.ready       = 1'b0;

      phase_types[0] = 32'h0000_0000;
      phase_types[1] = 32'hFFFF_FFFF;
      phase_types[2] = 32'h4944_4154;   // IDAT
      phase_types[3] = $urandom;
      phase_types[4] = 32'h4945_4E44;   // IEND

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: IHDR type, empty chunk, extremes, stray commands, abandon
      write_chunk_type(32'h4948_4452);
      send_request(CMD_START, 31'd0, 8'hFF);          // empty chunk, lengths agree
      send_request(CMD_END, 31'h7FFF_FFFF, 8'hFF);
      send_request(CMD_DATA, 31'h7FFF_FFFF, 8'h5A);   // data outside a chunk: dropped
      send_request(CMD_END, 31'd0, 8'h00);            // end outside a chunk: dropped
      send_request(CMD_NONE, 31'h7FFF_FFFF, 8'hFF);   // reserved command: dropped
      send_request(CMD_START, 31'h7FFF_FFFF, 8'h00);  // largest declared length
      send_request(CMD_DATA, 31'd0, 8'hFF);
      send_request(CMD_START, 31'd3, 8'h00);          // abandons the open chunk
      send_request(CMD_DATA, 31'h7FFF_FFFF, 8'h00);
      send_request(CMD_DATA, 31'd0, 8'hFF);
      send_request(CMD_NONE, 31'd0, 8'h00);           // reserved command inside a chunk
      send_request(CMD_DATA, 31'h5555_5555, 8'h80);
      send_request(CMD_END, 31'd0, 8'h00);            // count matches
      send_request(CMD_START, 31'd1, 8'hAA);
      send_request(CMD_DATA, 31'd0, 8'h01);
      send_request(CMD_DATA, 31'd0, 8'h02);
      send_request(CMD_END, 31'd0, 8'h00);            // one byte too many
      send_request(CMD_START, 31'd2, 8'h00);
      send_request(CMD_END, 31'd0, 8'h00);            // no data, two declared

      // random phases, each under its own chunk type; phase 2 runs without idling
      for (int p = 0; p < 5; p++) begin
         write_chunk_type(phase_types[p]);
         steady_flow = (p == 2);
         run_random_chunks(RANDOM_GOAL);
      end
      steady_flow = 1'b0;

      drain_results(SETTLE_CYCLES);

      $display("Checked %0d framed bytes: %0d chunks closed (%0d with a length mismatch),",
               tracker.checked, tracker.chunks_closed, tracker.bad_length_chunks);
      $display("%0d chunks abandoned by a new start, %0d commands dropped, 6 chunk types",
               tracker.abandoned, tracker.dropped);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d bytes still owed", tracker.mismatches,
                  tracker.pending());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
